FILE: rtl/aedt_pkg.sv
package aedt_pkg;

    localparam int COORD_W     = 15;
    localparam int SIDE_W      = 15;
    localparam int LIFE_W      = 16;
    localparam int DIST_W      = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_SIDE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIFE = 1'd1;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 15'd64;
    localparam logic [LIFE_W-1:0] LIFE_RESET = 16'd3000;

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [LIFE_W-1:0]  life;
    } entry_t;

endpackage

FILE: rtl/aedt_ifs.sv
interface aedt_item_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [aedt_pkg::COORD_W-1:0] corner_x;
    logic [aedt_pkg::COORD_W-1:0] corner_y;

    modport source (output valid, operation, corner_x, corner_y, input ready);
    modport sink (input valid, operation, corner_x, corner_y, output ready);
endinterface

interface aedt_result_if;
    logic                        valid;
    logic                        ready;
    logic [aedt_pkg::DIST_W-1:0] effective_distance;
    logic                        add_dropped;

    modport source (output valid, effective_distance, add_dropped, input ready);
    modport sink (input valid, effective_distance, add_dropped, output ready);
endinterface

FILE: rtl/aedt_store.sv
module aedt_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int CMPW  = 20
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  aedt_pkg::entry_t            wdata,
    input  logic [AW-1:0]               raddr,
    input  logic [CMPW-1:0]             px,
    input  logic [CMPW-1:0]             py,
    input  logic [aedt_pkg::SIDE_W-1:0] side,
    output aedt_pkg::entry_t            rdata,
    output logic                        hit,
    output logic                        expired
);

    aedt_pkg::entry_t mem [DEPTH];
    logic [CMPW-1:0]  cx;
    logic [CMPW-1:0]  cy;
    logic [CMPW-1:0]  sd;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    assign cx = CMPW'(rdata.cx);
    assign cy = CMPW'(rdata.cy);
    assign sd = CMPW'(side);
    assign hit = (cx <= px) && (px < cx + sd) && (cy <= py) && (py < cy + sd);
    assign expired = (rdata.life <= aedt_pkg::LIFE_W'(1));

endmodule

FILE: rtl/aedt_edge.sv
module aedt_edge #(
    parameter int DEPTH = 323,
    parameter int EAW   = 9
) (
    input  logic           clk,
    input  logic           we,
    input  logic [EAW-1:0] waddr,
    input  logic           covered,
    input  logic [EAW-1:0] raddr,
    output logic           cost
);

    logic mem [DEPTH];
    logic q;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= covered;
        end
        q <= mem[raddr];
    end

    // uncovered edge costs one
    assign cost = ~q;

endmodule

FILE: rtl/anomaly_effective_distance_tracker.sv
// Add item: accepted while idle, no result.
// Tick without pending recompute: emit raises the result once the output register is free, then each
// live anomaly is aged in a read and a compare state. Tick with recompute: edge marking visits each cell
// and on each lattice edge compares anomalies in turn (scan stops at first hit), then path relaxation runs
// over the edge memory column by column, then emit and the aging pass. One item in flight at a time.
// Reset (rst_n low, async) empties the store, sets a recompute pending and distance to DISTANCE.
module anomaly_effective_distance_tracker #(
    parameter int DISTANCE      = 9,
    parameter int MAX_ANOMALIES = 256,
    parameter int FRAC_BITS     = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    aedt_item_if.sink                        items,
    aedt_result_if.source                    results,
    input  logic                             wr_en,
    input  logic [aedt_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [aedt_pkg::CFG_DATA_W-1:0]  wr_data
);

    localparam int GRID_ROWS  = 2 * DISTANCE - 1;
    localparam int GRID_COLS  = 2 * DISTANCE + 1;
    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
    localparam int AW   = (MAX_ANOMALIES > 1) ? $clog2(MAX_ANOMALIES) : 1;
    localparam int CNTW = $clog2(MAX_ANOMALIES + 1);
    localparam int EAW  = $clog2(GRID_CELLS);
    localparam int XW   = $clog2(GRID_COLS);
    localparam int YW   = $clog2(GRID_ROWS);
    localparam int RW   = $clog2(DISTANCE);
    localparam int NW   = $clog2(DISTANCE + 2);
    localparam int PXW  = $clog2(4 * DISTANCE) + FRAC_BITS + 1;
    localparam int CMPW = (PXW > aedt_pkg::LIFE_W) ? PXW + 1 : aedt_pkg::LIFE_W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_COV_CELL, S_COV_RD, S_COV_CMP, S_RT_RD, S_RT_UPD, S_DN_RD, S_DN_UPD,
        S_UP_RD, S_UP_UPD, S_COL_NEXT, S_BEST, S_EMIT, S_AGE_RD, S_AGE_CMP
    } state_t;

    state_t                      state_reg, state_next;
    logic [aedt_pkg::SIDE_W-1:0] side_reg;
    logic [aedt_pkg::LIFE_W-1:0] life_reg;
    logic [CNTW-1:0]             count_reg, count_next;
    logic [CNTW-1:0]             kept_reg, kept_next;
    logic [AW-1:0]               ai_reg, ai_next;
    logic [XW-1:0]               x_reg, x_next;
    logic [YW-1:0]               y_reg, y_next;
    logic [EAW-1:0]              ea_reg, ea_next;
    logic [RW-1:0]               r_reg, r_next;
    logic [NW-1:0]               col_reg [DISTANCE];
    logic [NW-1:0]               col_next [DISTANCE];
    logic [NW-1:0]               carry_reg, carry_next;
    logic [NW-1:0]               best_reg, best_next;
    logic                        pending_reg, pending_next;
    logic                        dropped_reg, dropped_next;
    logic [aedt_pkg::DIST_W-1:0] last_reg, last_next;
    logic                        ov_reg, ov_next;
    logic [aedt_pkg::DIST_W-1:0] od_reg, od_next;
    logic                        odrop_reg, odrop_next;

    logic             s_we;
    logic [AW-1:0]    s_waddr;
    aedt_pkg::entry_t s_wdata;
    logic [AW-1:0]    s_raddr;
    aedt_pkg::entry_t s_rdata;
    logic             s_hit;
    logic             s_expired;
    logic [CMPW-1:0]  px;
    logic [CMPW-1:0]  py;
    logic             e_we;
    logic [EAW-1:0]   e_waddr;
    logic             e_covered;
    logic [EAW-1:0]   e_raddr;
    logic             e_cost;
    logic             in_acc;
    logic             is_edge;
    logic             cell_done;
    logic [NW-1:0]    cand;
    logic [NW-1:0]    newv;

    aedt_store #(.DEPTH(MAX_ANOMALIES), .AW(AW), .CMPW(CMPW)) u_store (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr),
        .px(px), .py(py), .side(side_reg), .rdata(s_rdata), .hit(s_hit),
        .expired(s_expired)
    );

    aedt_edge #(.DEPTH(GRID_CELLS), .EAW(EAW)) u_edge (
        .clk(clk), .we(e_we), .waddr(e_waddr), .covered(e_covered), .raddr(e_raddr),
        .cost(e_cost)
    );

    assign items.ready                = (state_reg == S_IDLE);
    assign in_acc                     = items.valid && items.ready;
    assign results.valid              = ov_reg;
    assign results.effective_distance = od_reg;
    assign results.add_dropped        = odrop_reg;

    assign px = CMPW'((int'(x_reg) + DISTANCE) << FRAC_BITS);
    assign py = CMPW'((int'(y_reg) + DISTANCE) << FRAC_BITS);
    assign is_edge = (x_reg >= XW'(1)) && (int'(x_reg) < 2 * DISTANCE)
                     && (x_reg[0] ^ y_reg[0]);
    assign cand = carry_reg + NW'(e_cost);
    assign newv = (cand < col_reg[r_reg]) ? cand : col_reg[r_reg];

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        kept_next    = kept_reg;
        ai_next      = ai_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        ea_next      = ea_reg;
        r_next       = r_reg;
        col_next     = col_reg;
        carry_next   = carry_reg;
        best_next    = best_reg;
        pending_next = pending_reg;
        dropped_next = dropped_reg;
        last_next    = last_reg;
        ov_next      = ov_reg;
        od_next      = od_reg;
        odrop_next   = odrop_reg;
        s_we         = 1'b0;
        s_waddr      = AW'(count_reg);
        s_wdata      = '{cx: items.corner_x, cy: items.corner_y, life: life_reg};
        s_raddr      = ai_reg;
        e_we         = 1'b0;
        e_waddr      = ea_reg;
        e_covered    = 1'b0;
        e_raddr      = ea_reg;
        cell_done    = 1'b0;

        if (ov_reg && results.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (items.operation == aedt_pkg::OP_ADD)
                    begin
                        if (int'(count_reg) < MAX_ANOMALIES)
                        begin
                            s_we         = 1'b1;
                            count_next   = count_reg + CNTW'(1);
                            pending_next = 1'b1;
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                    else if (pending_reg)
                    begin
                        pending_next = 1'b0;
                        x_next       = '0;
                        y_next       = '0;
                        ea_next      = '0;
                        state_next   = S_COV_CELL;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_COV_CELL:
            begin
                if (is_edge && (count_reg != '0))
                begin
                    ai_next    = '0;
                    state_next = S_COV_RD;
                end
                else
                begin
                    e_we      = 1'b1;
                    cell_done = 1'b1;
                end
            end
            S_COV_RD:
            begin
                state_next = S_COV_CMP;
            end
            S_COV_CMP:
            begin
                if (s_hit || (CNTW'(ai_reg) + CNTW'(1) == count_reg))
                begin
                    e_we      = 1'b1;
                    e_covered = s_hit;
                    cell_done = 1'b1;
                end
                else
                begin
                    ai_next    = ai_reg + AW'(1);
                    state_next = S_COV_RD;
                end
            end
            S_RT_RD:
            begin
                e_raddr    = EAW'(2 * int'(r_reg) * GRID_COLS + int'(x_reg) - 1);
                state_next = S_RT_UPD;
            end
            S_RT_UPD:
            begin
                col_next[r_reg] = col_reg[r_reg] + NW'(e_cost);
                if (int'(r_reg) == DISTANCE - 1)
                begin
                    r_next     = RW'(1);
                    carry_next = col_reg[0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    state_next = S_RT_RD;
                end
            end
            S_DN_RD:
            begin
                e_raddr    = EAW'((2 * int'(r_reg) - 1) * GRID_COLS + int'(x_reg));
                state_next = S_DN_UPD;
            end
            S_DN_UPD:
            begin
                col_next[r_reg] = newv;
                carry_next      = newv;
                if (int'(r_reg) == DISTANCE - 1)
                begin
                    r_next     = RW'(DISTANCE - 2);
                    state_next = S_UP_RD;
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    state_next = S_DN_RD;
                end
            end
            S_UP_RD:
            begin
                e_raddr    = EAW'((2 * int'(r_reg) + 1) * GRID_COLS + int'(x_reg));
                state_next = S_UP_UPD;
            end
            S_UP_UPD:
            begin
                col_next[r_reg] = newv;
                carry_next      = newv;
                if (r_reg == '0)
                begin
                    state_next = S_COL_NEXT;
                end
                else
                begin
                    r_next     = r_reg - RW'(1);
                    state_next = S_UP_RD;
                end
            end
            S_COL_NEXT:
            begin
                if (int'(x_reg) == 2 * DISTANCE)
                begin
                    best_next  = col_reg[0];
                    r_next     = RW'(1);
                    state_next = S_BEST;
                end
                else
                begin
                    x_next     = x_reg + XW'(2);
                    r_next     = '0;
                    state_next = S_RT_RD;
                end
            end
            S_BEST:
            begin
                if (col_reg[r_reg] < best_reg)
                begin
                    best_next = col_reg[r_reg];
                end
                if (int'(r_reg) == DISTANCE - 1)
                begin
                    last_next  = aedt_pkg::DIST_W'(best_next);
                    state_next = S_EMIT;
                end
                else
                begin
                    r_next = r_reg + RW'(1);
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || results.ready)
                begin
                    ov_next      = 1'b1;
                    od_next      = last_reg;
                    odrop_next   = dropped_reg;
                    dropped_next = 1'b0;
                    ai_next      = '0;
                    kept_next    = '0;
                    state_next   = (count_reg == '0) ? S_IDLE : S_AGE_RD;
                end
            end
            S_AGE_RD:
            begin
                state_next = S_AGE_CMP;
            end
            S_AGE_CMP:
            begin
                if (s_expired)
                begin
                    pending_next = 1'b1;
                end
                else
                begin
                    s_we      = 1'b1;
                    s_waddr   = AW'(kept_reg);
                    s_wdata   = '{cx: s_rdata.cx, cy: s_rdata.cy,
                                  life: s_rdata.life - aedt_pkg::LIFE_W'(1)};
                    kept_next = kept_reg + CNTW'(1);
                end
                if (CNTW'(ai_reg) + CNTW'(1) == count_reg)
                begin
                    count_next = kept_next;
                    state_next = S_IDLE;
                end
                else
                begin
                    ai_next    = ai_reg + AW'(1);
                    state_next = S_AGE_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cell_done)
        begin
            if (int'(ea_reg) == GRID_CELLS - 1)
            begin
                for (int i = 0; i < DISTANCE; i++)
                begin
                    col_next[i] = '0;
                end
                x_next     = XW'(2);
                r_next     = '0;
                state_next = S_RT_RD;
            end
            else
            begin
                ea_next    = ea_reg + EAW'(1);
                state_next = S_COV_CELL;
                if (int'(x_reg) == GRID_COLS - 1)
                begin
                    x_next = '0;
                    y_next = y_reg + YW'(1);
                end
                else
                begin
                    x_next = x_reg + XW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            side_reg    <= aedt_pkg::SIDE_RESET;
            life_reg    <= aedt_pkg::LIFE_RESET;
            count_reg   <= '0;
            pending_reg <= 1'b1;
            dropped_reg <= 1'b0;
            last_reg    <= aedt_pkg::DIST_W'(DISTANCE);
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            dropped_reg <= dropped_next;
            last_reg    <= last_next;
            ov_reg      <= ov_next;
            if (wr_en && (wr_index == aedt_pkg::REG_SIDE))
            begin
                side_reg <= aedt_pkg::SIDE_W'(wr_data);
            end
            if (wr_en && (wr_index == aedt_pkg::REG_LIFE))
            begin
                life_reg <= wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kept_reg  <= kept_next;
        ai_reg    <= ai_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        ea_reg    <= ea_next;
        r_reg     <= r_next;
        col_reg   <= col_next;
        carry_reg <= carry_next;
        best_reg  <= best_next;
        od_reg    <= od_next;
        odrop_reg <= odrop_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= MAX_ANOMALIES)
        else $error("live count above store depth");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (items.operation == aedt_pkg::OP_TICK) |=> !items.ready)
        else $error("tick did not occupy the sequencer");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (items.operation == aedt_pkg::OP_ADD)
        && (int'(count_reg) < MAX_ANOMALIES)
        |=> count_reg == $past(count_reg) + CNTW'(1))
        else $error("add did not grow the store");

    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

    a_compact: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AGE_CMP) |-> (kept_reg <= CNTW'(ai_reg)))
        else $error("compaction write ahead of read");

endmodule

FILE: tb/aedt_checker.sv
module aedt_checker #(
    parameter int DISTANCE      = 9,
    parameter int MAX_ANOMALIES = 256,
    parameter int FRAC_BITS     = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    aedt_item_if                             items,
    aedt_result_if                           results,
    input  logic                             wr_en,
    input  logic [aedt_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [aedt_pkg::CFG_DATA_W-1:0]  wr_data,
    output int                               fail_count,
    output int                               outstanding
);

    localparam int ROWS  = 2 * DISTANCE - 1;
    localparam int COLS  = 2 * DISTANCE + 1;
    localparam int CELLS = ROWS * COLS;

    typedef struct packed {
        logic [aedt_pkg::DIST_W-1:0] eff_dist;
        logic                        dropped;
    } tick_result_t;

    logic [aedt_pkg::SIDE_W-1:0] side;
    logic [aedt_pkg::LIFE_W-1:0] life;
    aedt_pkg::entry_t            anomalies [MAX_ANOMALIES];
    int                          live;
    logic                        covered [CELLS];
    int                          cost [CELLS];
    logic                        stale;
    logic [aedt_pkg::DIST_W-1:0] dist_now;
    logic                        dropped_now;
    tick_result_t                tick_results [$];

    function automatic logic edge_hit(int x, int y);
        int px;
        int py;
        px = (x + DISTANCE) << FRAC_BITS;
        py = (y + DISTANCE) << FRAC_BITS;
        for (int i = 0; i < live; i++)
            if (int'(anomalies[i].cx) <= px && px < int'(anomalies[i].cx) + int'(side) &&
                int'(anomalies[i].cy) <= py && py < int'(anomalies[i].cy) + int'(side))
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic int hop(int y, int x);
        return covered[y * COLS + x] ? 0 : 1;
    endfunction

    function automatic void find_distance();
        int c;
        int best;
        for (int y = 0; y < ROWS; y++)
            for (int x = 0; x < COLS; x++)
                covered[y * COLS + x] = (x >= 1 && x < 2 * DISTANCE && ((x + y) % 2 == 1))
                                        ? edge_hit(x, y) : 1'b0;
        for (int y = 0; y < ROWS; y += 2)
            cost[y * COLS] = 0;
        for (int x = 2; x < COLS; x += 2)
        begin
            for (int y = 0; y < ROWS; y += 2)
                cost[y * COLS + x] = cost[y * COLS + x - 2] + hop(y, x - 1);
            for (int y = 2; y < ROWS; y += 2)
            begin
                c = cost[(y - 2) * COLS + x] + hop(y - 1, x);
                if (c < cost[y * COLS + x])
                    cost[y * COLS + x] = c;
            end
            for (int y = ROWS - 1; y >= 2; y -= 2)
            begin
                c = cost[y * COLS + x] + hop(y - 1, x);
                if (c < cost[(y - 2) * COLS + x])
                    cost[(y - 2) * COLS + x] = c;
            end
        end
        best = DISTANCE * 10;
        for (int y = 0; y < ROWS; y += 2)
            if (cost[y * COLS + COLS - 1] < best)
                best = cost[y * COLS + COLS - 1];
        dist_now = aedt_pkg::DIST_W'(best);
    endfunction

    function automatic void apply_item(logic op, logic [aedt_pkg::COORD_W-1:0] x,
                                       logic [aedt_pkg::COORD_W-1:0] y);
        int kept;
        tick_result_t r;
        if (op == aedt_pkg::OP_ADD)
        begin
            if (live < MAX_ANOMALIES)
            begin
                anomalies[live] = '{cx: x, cy: y, life: life};
                live++;
                stale = 1'b1;
            end
            else
                dropped_now = 1'b1;
            return;
        end
        if (stale)
        begin
            find_distance();
            stale = 1'b0;
        end
        r.eff_dist = dist_now;
        r.dropped = dropped_now;
        tick_results = {tick_results, r};
        dropped_now = 1'b0;
        kept = 0;
        for (int i = 0; i < live; i++)
        begin
            if (anomalies[i].life <= 1)
            begin
                stale = 1'b1;
                continue;
            end
            anomalies[kept] = anomalies[i];
            anomalies[kept].life = anomalies[i].life - 1'b1;
            kept++;
        end
        live = kept;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t want;
        if (!rst_n)
        begin
            side = aedt_pkg::SIDE_RESET;
            life = aedt_pkg::LIFE_RESET;
            live = 0;
            foreach (covered[i])
                covered[i] = 1'b0;
            stale = 1'b1;
            dist_now = aedt_pkg::DIST_W'(DISTANCE);
            dropped_now = 1'b0;
            tick_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == aedt_pkg::REG_SIDE)
                    side = wr_data[aedt_pkg::SIDE_W-1:0];
                else if (wr_index == aedt_pkg::REG_LIFE)
                    life = wr_data[aedt_pkg::LIFE_W-1:0];
            end
            if (items.valid && items.ready)
                apply_item(items.operation, items.corner_x, items.corner_y);
            if (results.valid && results.ready)
            begin
                if (tick_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: dist %0d dropped %0b",
                                 results.effective_distance, results.add_dropped);
                end
                else
                begin
                    want = tick_results.pop_front();
                    if (want.eff_dist !== results.effective_distance ||
                        want.dropped !== results.add_dropped)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: dist exp %0d got %0d, dropped exp %0b got %0b",
                                     want.eff_dist, results.effective_distance,
                                     want.dropped, results.add_dropped);
                    end
                end
            end
        end
        outstanding = tick_results.size();
    end
endmodule

FILE: tb/testbench.sv
module testbench;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             wr_en = 1'b0;
    logic [aedt_pkg::CFG_INDEX_W-1:0] wr_index = aedt_pkg::REG_SIDE;
    logic [aedt_pkg::CFG_DATA_W-1:0]  wr_data = '0;
    int                               fail_count;
    int                               outstanding;
    int                               send_idle = 8;
    int                               recv_idle = 60;
    logic                             hold = 1'b0;

    aedt_item_if   items ();
    aedt_result_if results ();

    anomaly_effective_distance_tracker u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .results  (results),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    aedt_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items),
        .results     (results),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    initial
    begin
        items.valid = 1'b0;
        items.operation = aedt_pkg::OP_TICK;
        items.corner_x = '0;
        items.corner_y = '0;
        results.ready = 1'b0;
    end

    always @(posedge clk)
        results.ready <= !hold && ($urandom_range(99) >= recv_idle);

    task automatic send(logic op, int x, int y);
        while ($urandom_range(99) < send_idle)
        begin
            items.valid <= 1'b0;
            @(posedge clk);
        end
        items.valid <= 1'b1;
        items.operation <= op;
        items.corner_x <= aedt_pkg::COORD_W'(x);
        items.corner_y <= aedt_pkg::COORD_W'(y);
        do
            @(posedge clk);
        while (!items.ready);
    endtask

    task automatic settle();
        items.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic write_reg(logic [aedt_pkg::CFG_INDEX_W-1:0] idx, int value);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= aedt_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_add();
        if ($urandom_range(9) < 7)
            send(aedt_pkg::OP_ADD, $urandom_range(7000, 1800), $urandom_range(7000, 1800));
        else
            send(aedt_pkg::OP_ADD, $urandom_range(31743), $urandom_range(31743));
    endtask

    task automatic random_phase(int count);
        int s;
        s = $urandom_range(2);
        write_reg(aedt_pkg::REG_SIDE, s == 0 ? 0 : s == 1 ? 32767 : $urandom_range(2048, 128));
        write_reg(aedt_pkg::REG_LIFE, $urandom_range(8, 1));
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 40)
                send(aedt_pkg::OP_TICK, $urandom_range(31743), $urandom_range(31743));
            else
                random_add();
        end
        settle();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(aedt_pkg::OP_TICK, 0, 0);
        send(aedt_pkg::OP_ADD, 0, 0);
        send(aedt_pkg::OP_ADD, 31743, 31743);
        send(aedt_pkg::OP_ADD, 2560, 2560);
        send(aedt_pkg::OP_TICK, 31743, 31743);
        send(aedt_pkg::OP_TICK, 0, 0);
        settle();
        write_reg(aedt_pkg::REG_SIDE, 32767);
        write_reg(aedt_pkg::REG_LIFE, 1);
        send(aedt_pkg::OP_ADD, 0, 0);
        send(aedt_pkg::OP_TICK, 0, 0);
        send(aedt_pkg::OP_TICK, 0, 0);
        settle();
        write_reg(aedt_pkg::REG_LIFE, 65535);
        write_reg(aedt_pkg::REG_SIDE, 0);
        send(aedt_pkg::OP_ADD, 2560, 2560);
        send(aedt_pkg::OP_TICK, 0, 0);
        settle();
        // fill the store, then overflow it
        write_reg(aedt_pkg::REG_LIFE, 1);
        write_reg(aedt_pkg::REG_SIDE, 256);
        send(aedt_pkg::OP_TICK, 0, 0);
        for (int i = 0; i < 259; i++)
            random_add();
        send(aedt_pkg::OP_TICK, 0, 0);
        send(aedt_pkg::OP_TICK, 0, 0);
        send(aedt_pkg::OP_TICK, 0, 0);
        settle();

        fork
            random_phase(260);
            begin
                repeat (200) @(posedge clk);
                hold <= 1'b1;
                repeat (3000) @(posedge clk);
                hold <= 1'b0;
            end
        join
        send_idle = 60;
        recv_idle = 8;
        random_phase(260);
        send_idle = 0;
        recv_idle = 0;
        random_phase(260);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #(8 * 30_000_000);
        $display("simulation failed");
        $finish;
    end
endmodule
